[sv/clt_pkg.sv]
// shared types, codes and constants of the command line tokenizer
package clt_pkg;

    // most tokens a line may hold, whatever max_tokens says
    localparam int TOKEN_LIMIT = 16;

    // result queue depth and pointer width
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // register indexes of the configuration port
    localparam logic CFG_MAX_TOKENS    = 1'b0;
    localparam logic CFG_COPY_CAPACITY = 1'b1;

    // reset values of the configuration registers
    localparam logic [4:0]  MAX_TOKENS_RESET    = 5'd16;
    localparam logic [12:0] COPY_CAPACITY_RESET = 13'd4096;

    // characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINE = 2'd2
    } t_kind;

    // line error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED = 2'd1;
    localparam logic [1:0] ERR_TOO_MANY = 2'd2;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [3:0]  token_index;
        logic [7:0]  token_length;
        logic        quoted;
        logic [4:0]  token_count;
        logic [1:0]  error_code;
        logic        last;
    } t_result;

    // results of one input byte, handed to the queue
    typedef struct packed {
        logic [1:0]  count;
        t_result     res0;
        t_result     res1;
    } t_push;

    // queue status seen by the scanner
    typedef struct packed {
        logic        room2;
    } t_queue_stat;

    // length counter that saturates at 255
    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

endpackage

[sv/clt_scanner.sv]
// input register, configuration registers and per-byte scanning logic
module clt_scanner (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    input  logic                 i_char_valid,
    output logic                 o_char_ready,
    input  logic [7:0]           i_char,
    input  clt_pkg::t_queue_stat i_stat,
    output clt_pkg::t_push       o_push
);

    typedef enum logic [2:0] {
        M_BETWEEN = 3'd0,
        M_PLAIN   = 3'd1,
        M_QUOTED  = 3'd2,
        M_QESC    = 3'd3,
        M_COMMENT = 3'd4,
        M_IGNORE  = 3'd5
    } t_mode;

    logic        r_valid;
    logic [7:0]  r_char;
    logic [4:0]  r_max;
    logic [12:0] r_cap;

    t_mode       r_mode, n_mode;
    logic [4:0]  r_tf, n_tf;
    logic [12:0] r_used, n_used;
    logic [12:0] r_left, n_left;
    logic [7:0]  r_cur, n_cur;
    logic [1:0]  r_err, n_err;

    logic             fire;
    logic [4:0]       limit;
    logic             is_sep;
    logic             do_qchar;
    logic             clear;
    logic [7:0]       cur_q;
    logic [7:0]       qlen;
    logic             v_a, v_b;
    clt_pkg::t_result res_a, res_b;

    function automatic clt_pkg::t_result mk_byte(input logic [7:0] c, input logic [4:0] idx,
                                                 input logic [7:0] len, input logic q);
        clt_pkg::t_result r;
        r = '0;
        r.kind         = clt_pkg::KIND_BYTE;
        r.data_byte    = c;
        r.token_index  = idx[3:0];
        r.token_length = len;
        r.quoted       = q;
        return r;
    endfunction

    function automatic clt_pkg::t_result mk_end(input logic [4:0] idx, input logic [7:0] len,
                                                input logic q);
        clt_pkg::t_result r;
        r = '0;
        r.kind         = clt_pkg::KIND_END;
        r.token_index  = idx[3:0];
        r.token_length = len;
        r.quoted       = q;
        return r;
    endfunction

    function automatic clt_pkg::t_result mk_line(input logic [4:0] cnt, input logic [1:0] err);
        clt_pkg::t_result r;
        r = '0;
        r.kind        = clt_pkg::KIND_LINE;
        r.token_count = cnt;
        r.error_code  = err;
        return r;
    endfunction

    // a held byte is scanned once the queue has room for two results
    assign fire         = r_valid && i_stat.room2;
    assign o_char_ready = !r_valid || fire;

    // effective token limit
    assign limit  = (int'(r_max) < clt_pkg::TOKEN_LIMIT) ? r_max : 5'(clt_pkg::TOKEN_LIMIT);
    assign is_sep = (r_char == clt_pkg::CH_SPACE) || (r_char == clt_pkg::CH_TAB);
    assign qlen   = ({5'd0, cur_q} > r_left) ? r_left[7:0] : cur_q;

    // scanning of one byte: up to two results, first slot a then slot b
    always_comb begin
        n_mode   = r_mode;
        n_tf     = r_tf;
        n_used   = r_used;
        n_left   = r_left;
        n_cur    = r_cur;
        n_err    = r_err;
        v_a      = 1'b0;
        v_b      = 1'b0;
        res_a    = '0;
        res_b    = '0;
        cur_q    = r_cur;
        do_qchar = 1'b0;
        clear    = 1'b0;
        if (fire) begin
            unique case (r_mode)
                M_PLAIN: begin
                    if (r_char == clt_pkg::CH_NUL) begin
                        v_a   = 1'b1;
                        res_a = mk_end(r_tf, r_cur, 1'b0);
                        v_b   = 1'b1;
                        res_b = mk_line(r_tf + 5'd1, clt_pkg::ERR_NONE);
                        clear = 1'b1;
                    end else if (is_sep || r_char == clt_pkg::CH_HASH) begin
                        v_a    = 1'b1;
                        res_a  = mk_end(r_tf, r_cur, 1'b0);
                        n_tf   = r_tf + 5'd1;
                        n_cur  = '0;
                        n_mode = is_sep ? M_BETWEEN : M_COMMENT;
                    end else begin
                        v_a   = 1'b1;
                        res_a = mk_byte(r_char, r_tf, r_cur, 1'b0);
                        n_cur = clt_pkg::sat_inc(r_cur);
                    end
                end
                M_QUOTED: begin
                    do_qchar = 1'b1;
                end
                M_QESC: begin
                    n_mode = M_QUOTED;
                    if (r_char == clt_pkg::CH_DQUOTE || r_char == clt_pkg::CH_BSLASH) begin
                        v_a   = {5'd0, r_cur} < r_left;
                        res_a = mk_byte(r_char, r_tf, r_cur, 1'b1);
                        n_cur = clt_pkg::sat_inc(r_cur);
                    end else begin
                        // lone backslash is kept, the byte after it scanned as usual
                        v_a      = {5'd0, r_cur} < r_left;
                        res_a    = mk_byte(clt_pkg::CH_BSLASH, r_tf, r_cur, 1'b1);
                        cur_q    = clt_pkg::sat_inc(r_cur);
                        n_cur    = cur_q;
                        do_qchar = 1'b1;
                    end
                end
                M_COMMENT, M_IGNORE: begin
                    if (r_char == clt_pkg::CH_NUL) begin
                        v_b   = 1'b1;
                        res_b = mk_line((r_err != clt_pkg::ERR_NONE) ? 5'd0 : r_tf, r_err);
                        clear = 1'b1;
                    end
                end
                default: begin
                    if (r_char == clt_pkg::CH_NUL) begin
                        v_b   = 1'b1;
                        res_b = mk_line((r_err != clt_pkg::ERR_NONE) ? 5'd0 : r_tf, r_err);
                        clear = 1'b1;
                    end else if (is_sep) begin
                        n_mode = r_mode;
                    end else if (r_char == clt_pkg::CH_HASH) begin
                        n_mode = M_COMMENT;
                    end else if (r_tf >= limit) begin
                        n_err  = clt_pkg::ERR_TOO_MANY;
                        n_mode = M_IGNORE;
                    end else if (r_char == clt_pkg::CH_DQUOTE) begin
                        n_mode = M_QUOTED;
                        n_cur  = '0;
                        n_left = (r_used <= r_cap) ? r_cap - r_used : '0;
                    end else begin
                        n_mode = M_PLAIN;
                        v_a    = 1'b1;
                        res_a  = mk_byte(r_char, r_tf, 8'd0, 1'b0);
                        n_cur  = 8'd1;
                    end
                end
            endcase

            // byte inside quotes
            if (do_qchar) begin
                priority if (r_char == clt_pkg::CH_NUL) begin
                    v_b   = 1'b1;
                    res_b = mk_line(5'd0, clt_pkg::ERR_UNCLOSED);
                    clear = 1'b1;
                end else if (r_char == clt_pkg::CH_DQUOTE) begin
                    v_b    = 1'b1;
                    res_b  = mk_end(r_tf, qlen, 1'b1);
                    n_used = r_used + {5'd0, qlen};
                    n_tf   = r_tf + 5'd1;
                    n_cur  = '0;
                    n_mode = M_BETWEEN;
                end else if (r_char == clt_pkg::CH_BSLASH) begin
                    n_mode = M_QESC;
                end else begin
                    v_b   = {5'd0, cur_q} < r_left;
                    res_b = mk_byte(r_char, r_tf, cur_q, 1'b1);
                    n_cur = clt_pkg::sat_inc(cur_q);
                end
            end

            // line done returns all per-line state to reset
            if (clear) begin
                n_mode = M_BETWEEN;
                n_tf   = '0;
                n_used = '0;
                n_left = '0;
                n_cur  = '0;
                n_err  = clt_pkg::ERR_NONE;
            end
        end
    end

    // pack the results front first, marking the last one
    always_comb begin
        o_push       = '0;
        o_push.count = {1'b0, v_a} + {1'b0, v_b};
        o_push.res0  = v_a ? res_a : res_b;
        o_push.res1  = res_b;
        if (v_a && v_b) begin
            o_push.res1.last = 1'b1;
        end else begin
            o_push.res0.last = 1'b1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_char_ready) begin
            r_valid <= i_char_valid;
        end
        if (o_char_ready && i_char_valid) begin
            r_char <= i_char;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= clt_pkg::MAX_TOKENS_RESET;
            r_cap <= clt_pkg::COPY_CAPACITY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                clt_pkg::CFG_MAX_TOKENS:    r_max <= i_cfg_data[4:0];
                clt_pkg::CFG_COPY_CAPACITY: r_cap <= i_cfg_data;
                default:                    r_cap <= r_cap;
            endcase
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_BETWEEN;
            r_tf   <= '0;
            r_used <= '0;
            r_left <= '0;
            r_cur  <= '0;
            r_err  <= clt_pkg::ERR_NONE;
        end else begin
            r_mode <= n_mode;
            r_tf   <= n_tf;
            r_used <= n_used;
            r_left <= n_left;
            r_cur  <= n_cur;
            r_err  <= n_err;
        end
    end

endmodule

[sv/clt_result_queue.sv]
// small result queue: takes up to two results a cycle, gives one
module clt_result_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  clt_pkg::t_push       i_push,
    output clt_pkg::t_queue_stat o_stat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output clt_pkg::t_result     o_head
);

    clt_pkg::t_result                  r_mem [clt_pkg::QUEUE_DEPTH];
    logic [clt_pkg::QUEUE_PTR_W-1:0]   r_wr, r_rd;
    logic [clt_pkg::QUEUE_PTR_W:0]     r_cnt;
    logic [clt_pkg::QUEUE_PTR_W-1:0]   wr_next;
    logic                              pop;

    assign wr_next      = r_wr + {{(clt_pkg::QUEUE_PTR_W-1){1'b0}}, 1'b1};
    assign pop          = o_valid && i_ready;
    assign o_valid      = r_cnt != '0;
    assign o_head       = r_mem[r_rd];
    assign o_stat.room2 = int'(r_cnt) <= clt_pkg::QUEUE_DEPTH - 2;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + i_push.count[clt_pkg::QUEUE_PTR_W-1:0];
            r_rd  <= r_rd + {{(clt_pkg::QUEUE_PTR_W-1){1'b0}}, pop};
            r_cnt <= r_cnt + {{(clt_pkg::QUEUE_PTR_W-1){1'b0}}, i_push.count}
                           - {{clt_pkg::QUEUE_PTR_W{1'b0}}, pop};
        end
    end

endmodule

[sv/command_line_tokenizer.sv]
// Command line tokenizer: takes one byte of a line per clock on the slave stream, unless
// stalled, and streams token bytes, token ends and a line-done summary on the master
// stream. A byte is registered, scanned combinationally and lands in a four-entry result
// queue, so the sustained rate is one byte per clock while each byte gives at most one
// result and the output is ready. A byte that gives two results (a plain token closed by
// end of line, or a lone backslash inside quotes followed by a kept byte or end of line)
// sends them one at a time; the input stalls only when the queue has no room for two
// results, as the output drains it. The configuration port is always ready; the user must
// write it only while no line is being scanned; the block itself does not enforce this.
module command_line_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // input bytes
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // char_in[7:0]
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // data_byte[7:0], token_index[11:8],
                                          // token_length[19:12], quoted[20],
                                          // token_count[25:21], error_code[27:26], zero
    output logic [1:0]  o_m_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tlast    // last result of an input byte
);

    clt_pkg::t_push       push;
    clt_pkg::t_queue_stat stat;
    clt_pkg::t_result     head;

    assign o_cfg_ready = 1'b1;

    // scanner
    clt_scanner u_scanner (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_char_valid (i_s_axis_tvalid),
        .o_char_ready (o_s_axis_tready),
        .i_char       (i_s_axis_tdata),
        .i_stat       (stat),
        .o_push       (push)
    );

    // result queue
    clt_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stat  (stat),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_head  (head)
    );

    // output packing
    assign o_m_axis_tdata = {4'd0, head.error_code, head.token_count, head.quoted,
                             head.token_length, head.token_index, head.data_byte};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule

[sv/clt_checker.sv]
// port-level checks of the command line tokenizer, bound to the top level
module clt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // a result never carries an unused kind
    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != 2'd3)
        else $error("result kind out of range");

    // line done is always the last result of its byte
    a_line_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == clt_pkg::KIND_LINE) |-> o_m_axis_tlast)
        else $error("line done without tlast");

    // a failed line reports no tokens
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == clt_pkg::KIND_LINE
         && o_m_axis_tdata[27:26] != clt_pkg::ERR_NONE) |-> o_m_axis_tdata[25:21] == 5'd0)
        else $error("error line with nonzero token count");

    // token results carry no count or error
    a_token_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != clt_pkg::KIND_LINE)
        |-> o_m_axis_tdata[27:21] == 7'd0)
        else $error("token result with count or error set");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
         && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[tb/command_line_tokenizer_tb.sv]
// self-checking testbench of the command line tokenizer: predicts each result and compares
`timescale 1ns / 100ps

module command_line_tokenizer_tb;

    // scanner position within a line
    typedef enum logic [2:0] {
        SCAN_GAP,
        SCAN_PLAIN,
        SCAN_QUOTED,
        SCAN_ESCAPE,
        SCAN_COMMENT,
        SCAN_SKIP
    } t_scan;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = clt_pkg::CFG_MAX_TOKENS;
    logic [12:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;   // char_in[7:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // data_byte, token_index, token_length, quoted,
                                        // token_count, error_code, zero
    logic [1:0]  o_m_axis_tuser;        // kind
    logic        o_m_axis_tlast;

    command_line_tokenizer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // predictor copy of configuration and line state
    logic [4:0]  max_tok_reg = clt_pkg::MAX_TOKENS_RESET;
    logic [12:0] copy_cap_reg = clt_pkg::COPY_CAPACITY_RESET;
    t_scan       scan = SCAN_GAP;
    logic [4:0]  tok_found = '0;
    logic [12:0] copy_used = '0;
    logic [12:0] copy_left = '0;
    logic [7:0]  cur_len = '0;
    logic [1:0]  line_err = clt_pkg::ERR_NONE;

    clt_pkg::t_result step_res[2];
    int               step_n;
    clt_pkg::t_result expected_results[$];
    int               mismatch_count = 0;
    int               items_sent = 0;

    // sender and receiver idling controls
    int          gap_max = 0;
    int          burst_left = 0;
    int          stall_pct = 0;

    // length that sticks at 255
    function automatic logic [7:0] bump_len(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic void add_res(input clt_pkg::t_kind k, input logic [7:0] d,
                                    input logic [3:0] idx, input logic [7:0] len,
                                    input logic q, input logic [4:0] cnt,
                                    input logic [1:0] err);
        clt_pkg::t_result r;
        r.kind         = k;
        r.data_byte    = d;
        r.token_index  = idx;
        r.token_length = len;
        r.quoted       = q;
        r.token_count  = cnt;
        r.error_code   = err;
        r.last         = 1'b0;
        step_res[step_n] = r;
        step_n++;
    endfunction

    // line summary, then back to a fresh line
    function automatic void end_line();
        add_res(clt_pkg::KIND_LINE, 8'd0, 4'd0, 8'd0, 1'b0,
                (line_err != clt_pkg::ERR_NONE) ? 5'd0 : tok_found, line_err);
        scan      = SCAN_GAP;
        tok_found = '0;
        copy_used = '0;
        copy_left = '0;
        cur_len   = '0;
        line_err  = clt_pkg::ERR_NONE;
    endfunction

    // quoted byte, kept only while the budget taken at the opening quote lasts
    function automatic void keep_quoted(input logic [7:0] c);
        if (cur_len < copy_left)
            add_res(clt_pkg::KIND_BYTE, c, tok_found[3:0], cur_len, 1'b1, 5'd0,
                    clt_pkg::ERR_NONE);
        cur_len = bump_len(cur_len);
    endfunction

    function automatic void close_token(input logic q);
        logic [7:0] len;
        len = cur_len;
        if (q) begin
            if (len > copy_left)
                len = copy_left[7:0];
            copy_used = copy_used + 13'(len);
        end
        add_res(clt_pkg::KIND_END, 8'd0, tok_found[3:0], len, q, 5'd0, clt_pkg::ERR_NONE);
        tok_found = tok_found + 5'd1;
        cur_len   = '0;
        scan      = SCAN_GAP;
    endfunction

    function automatic void quoted_char(input logic [7:0] c);
        if (c == clt_pkg::CH_NUL) begin
            line_err = clt_pkg::ERR_UNCLOSED;
            end_line();
        end else if (c == clt_pkg::CH_DQUOTE) begin
            close_token(1'b1);
        end else if (c == clt_pkg::CH_BSLASH) begin
            scan = SCAN_ESCAPE;
        end else begin
            keep_quoted(c);
        end
    endfunction

    // expected results of one accepted byte
    function automatic void tokenize_char(input logic [7:0] c);
        logic [4:0] limit;
        limit  = (max_tok_reg < clt_pkg::TOKEN_LIMIT) ? max_tok_reg
                                                       : 5'(clt_pkg::TOKEN_LIMIT);
        step_n = 0;
        case (scan)
            SCAN_PLAIN: begin
                if (c == clt_pkg::CH_NUL) begin
                    close_token(1'b0);
                    end_line();
                end else if (c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB) begin
                    close_token(1'b0);
                end else if (c == clt_pkg::CH_HASH) begin
                    close_token(1'b0);
                    scan = SCAN_COMMENT;
                end else begin
                    add_res(clt_pkg::KIND_BYTE, c, tok_found[3:0], cur_len, 1'b0, 5'd0,
                            clt_pkg::ERR_NONE);
                    cur_len = bump_len(cur_len);
                end
            end
            SCAN_QUOTED: quoted_char(c);
            SCAN_ESCAPE: begin
                scan = SCAN_QUOTED;
                if (c == clt_pkg::CH_DQUOTE || c == clt_pkg::CH_BSLASH) begin
                    keep_quoted(c);
                end else begin
                    keep_quoted(clt_pkg::CH_BSLASH);
                    quoted_char(c);
                end
            end
            SCAN_COMMENT, SCAN_SKIP: begin
                if (c == clt_pkg::CH_NUL)
                    end_line();
            end
            default: begin
                if (c == clt_pkg::CH_NUL) begin
                    end_line();
                end else if (c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB) begin
                    // separator, nothing to do
                end else if (c == clt_pkg::CH_HASH) begin
                    scan = SCAN_COMMENT;
                end else if (tok_found >= limit) begin
                    line_err = clt_pkg::ERR_TOO_MANY;
                    scan     = SCAN_SKIP;
                end else if (c == clt_pkg::CH_DQUOTE) begin
                    scan      = SCAN_QUOTED;
                    cur_len   = '0;
                    copy_left = (copy_used <= copy_cap_reg) ? copy_cap_reg - copy_used : '0;
                end else begin
                    scan = SCAN_PLAIN;
                    add_res(clt_pkg::KIND_BYTE, c, tok_found[3:0], 8'd0, 1'b0, 5'd0,
                            clt_pkg::ERR_NONE);
                    cur_len = 8'd1;
                end
            end
        endcase
        if (step_n > 0)
            step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_results.push_back(step_res[i]);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : result_check
        clt_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d tdata %h", o_m_axis_tuser, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, o_m_axis_tuser);
                check_field("data_byte", want.data_byte, o_m_axis_tdata[7:0]);
                check_field("token_index", want.token_index, o_m_axis_tdata[11:8]);
                check_field("token_length", want.token_length, o_m_axis_tdata[19:12]);
                check_field("quoted", want.quoted, o_m_axis_tdata[20]);
                check_field("token_count", want.token_count, o_m_axis_tdata[25:21]);
                check_field("error_code", want.error_code, o_m_axis_tdata[27:26]);
                check_field("last", want.last, o_m_axis_tlast);
            end
        end
    end

    // receiver stalls at its own random rate
    always @(negedge i_clk)
        i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // one byte in, with bursts and gaps on the sender side
    task automatic send_char(input logic [7:0] c);
        int k;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            k = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            repeat (k) @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tokenize_char(c);
        items_sent++;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
        send_char(clt_pkg::CH_NUL);
    endtask

    // sender holds off until every expected result is out
    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
            expected_results.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == clt_pkg::CFG_MAX_TOKENS)
            max_tok_reg = val[4:0];
        else
            copy_cap_reg = val;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int max_tok, input int cap);
        wait_drained();
        write_reg(clt_pkg::CFG_MAX_TOKENS, 13'(max_tok));
        write_reg(clt_pkg::CFG_COPY_CAPACITY, 13'(cap));
    endtask

    // random token byte, never one that would end or split the token
    function automatic logic [7:0] pick_byte(input bit in_quotes, input bit first);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (in_quotes ? (c == clt_pkg::CH_DQUOTE || c == clt_pkg::CH_BSLASH)
                         : (c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB ||
                            c == clt_pkg::CH_HASH ||
                            (first && c == clt_pkg::CH_DQUOTE)));
        return c;
    endfunction

    function automatic int token_len(input int shortest);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                           : $urandom_range(shortest, 8);
    endfunction

    task automatic send_seps(input int n);
        repeat (n) send_char($urandom_range(0, 1) ? clt_pkg::CH_SPACE : clt_pkg::CH_TAB);
    endtask

    task automatic send_plain(input int len);
        for (int i = 0; i < len; i++)
            send_char(pick_byte(1'b0, i == 0));
    endtask

    // quoted token with escapes, lone backslashes and separators inside
    task automatic send_quoted(input int len, input bit closed);
        send_char(clt_pkg::CH_DQUOTE);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0: begin send_char(clt_pkg::CH_BSLASH); send_char(clt_pkg::CH_DQUOTE); end
                1: begin send_char(clt_pkg::CH_BSLASH); send_char(clt_pkg::CH_BSLASH); end
                2: begin
                    send_char(clt_pkg::CH_BSLASH);
                    send_char(pick_byte(1'b1, 1'b0));
                end
                3: send_char($urandom_range(0, 1) ? clt_pkg::CH_SPACE : clt_pkg::CH_HASH);
                default: send_char(pick_byte(1'b1, 1'b0));
            endcase
        end
        if (closed)
            send_char(clt_pkg::CH_DQUOTE);
    endtask

    // short lines covering every kind of result and the corner cases
    task automatic test_basic_lines();
        gap_max   = 2;
        stall_pct = 25;
        set_config(16, 4096);
        // tab separator, quoted space, closing quote then comment
        send_line("a\t\"b c\"#x");
        // escaped quote and backslash, lone backslash before a byte and before end
        send_line("\"\\\"\\\\\\q\\");
        // high bytes in a plain token closed by a comment
        send_char(8'hFF);
        send_char(8'h80);
        send_line("#");
        // empty quoted token, then a plain one closed by end of line
        send_line("\"\"z");
        send_line("");
    endtask

    task automatic test_token_limit();
        gap_max   = 3;
        stall_pct = 40;
        set_config(0, 4096);
        send_line("a");
        send_line("  \t");
        set_config(1, 4096);
        send_line("a \"b\" c");
        set_config(31, 4096);
        send_line("a b c d e f g h i j k l m n o p");
        send_line("a b c d e f g h i j k l m n o p q");
        set_config(16, 4096);
        send_line("0 1 2 3 4 5 6 7 8 9 a b c d e f #x");
        send_line("0 1 2 3 4 5 6 7 8 9 a b c d e f \"g");
    endtask

    task automatic test_copy_budget();
        gap_max   = 1;
        stall_pct = 50;
        set_config(16, 0);
        send_line("\"abc\" de \"\"");
        set_config(16, 5);
        send_line("\"abc\"\"defg\" \"h\" ij");
        send_line("\"xy");
        set_config(16, 4096);
        send_line("\"abc\" \"de\"");
    endtask

    // lengths and positions stick at 255
    task automatic test_long_tokens();
        gap_max   = 0;
        stall_pct = 20;
        set_config(16, 4096);
        repeat (258) send_char("k");
        send_char(clt_pkg::CH_SPACE);
        send_char(clt_pkg::CH_DQUOTE);
        repeat (258) send_char("m");
        send_line("\"");
    endtask

    task automatic send_random_line();
        int n_tok;
        int roll;
        // pure noise, any byte at all
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
            send_char(clt_pkg::CH_NUL);
            return;
        end
        n_tok = $urandom_range(0, 7);
        send_seps($urandom_range(0, 2));
        for (int t = 0; t < n_tok; t++) begin
            if ($urandom_range(0, 99) < 55) begin
                send_plain(token_len(1));
                send_seps($urandom_range((t == n_tok - 1) ? 0 : 1, 3));
            end else begin
                send_quoted(token_len(0), 1'b1);
                send_seps($urandom_range(0, 2));
            end
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            send_char(clt_pkg::CH_HASH);
            repeat ($urandom_range(0, 6)) send_char(8'($urandom_range(1, 255)));
        end else if (roll < 18) begin
            send_quoted(token_len(0), 1'b0);
            if ($urandom_range(0, 1))
                send_char(clt_pkg::CH_BSLASH);
        end
        send_char(clt_pkg::CH_NUL);
    endtask

    // random lines over several settings and idling levels
    task automatic test_random_lines();
        int phase_start;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin set_config(16, 4096); gap_max = 0; stall_pct = 0; end
                1: begin set_config(3, 12); gap_max = 3; stall_pct = 30; end
                2: begin set_config($urandom_range(2, 6), 0); gap_max = 6; stall_pct = 60; end
                3: begin set_config(31, 40); gap_max = 2; stall_pct = 80; end
                4: begin
                    set_config(8, $urandom_range(0, 4096));
                    gap_max = 8;
                    stall_pct = 10;
                end
                default: begin
                    set_config($urandom_range(0, 16), $urandom_range(0, 60));
                    gap_max = 4;
                    stall_pct = 50;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 18)
                send_random_line();
        end
    endtask

    // run limit
    initial begin
        #10_000_000;
        $display("command_line_tokenizer_tb NOT OK");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        test_basic_lines();
        test_token_limit();
        test_copy_budget();
        test_long_tokens();
        test_random_lines();
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("command_line_tokenizer_tb OK");
        else
            $display("command_line_tokenizer_tb NOT OK");
        $finish;
    end

endmodule

[sim.f]
sv/clt_pkg.sv
sv/clt_scanner.sv
sv/clt_result_queue.sv
sv/command_line_tokenizer.sv
sv/clt_checker.sv
tb/command_line_tokenizer_tb.sv
